### hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the shader source tokenizer
// token kinds, lexer modes, keyword table and the token record
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int POSITION_BITS = 16;
   localparam int KEYWORD_CHARS = 9;
   localparam int KW_IDX_BITS   = $clog2(KEYWORD_CHARS);
   localparam int KW_BITS       = KEYWORD_CHARS * 8;
   localparam int KW_COUNT      = 10;

   localparam int START_BITS = 16;
   localparam int LEN_BITS   = 16;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   localparam int CH_BITS   = 8;
   localparam int KIND_BITS = 5;
   localparam int TOKEN_BITS = KIND_BITS + START_BITS + LEN_BITS;
   localparam int DATA_BITS  = ((TOKEN_BITS + 7) / 8) * 8;
   localparam int DATA_PAD   = DATA_BITS - TOKEN_BITS;

   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_DEPTH    = 1 << FIFO_PTR_BITS;
   localparam int FIFO_LVL_BITS = FIFO_PTR_BITS + 1;

   localparam logic [CH_BITS-1:0] CH_NUL      = 8'h00;
   localparam logic [CH_BITS-1:0] CH_NEWLINE  = 8'h0A;
   localparam logic [CH_BITS-1:0] CH_SPACE    = 8'h20;
   localparam logic [CH_BITS-1:0] CH_COLON    = 8'h3A;
   localparam logic [CH_BITS-1:0] CH_MINUS    = 8'h2D;
   localparam logic [CH_BITS-1:0] CH_GT       = 8'h3E;
   localparam logic [CH_BITS-1:0] CH_LT       = 8'h3C;
   localparam logic [CH_BITS-1:0] CH_EQUALS   = 8'h3D;
   localparam logic [CH_BITS-1:0] CH_DOT      = 8'h2E;
   localparam logic [CH_BITS-1:0] CH_AT       = 8'h40;
   localparam logic [CH_BITS-1:0] CH_UNDER    = 8'h5F;
   localparam logic [CH_BITS-1:0] CH_PLUS     = 8'h2B;
   localparam logic [CH_BITS-1:0] CH_STAR     = 8'h2A;
   localparam logic [CH_BITS-1:0] CH_SLASH    = 8'h2F;
   localparam logic [CH_BITS-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [CH_BITS-1:0] CH_RBRACE   = 8'h7D;
   localparam logic [CH_BITS-1:0] CH_LPAREN   = 8'h28;
   localparam logic [CH_BITS-1:0] CH_RPAREN   = 8'h29;
   localparam logic [CH_BITS-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CH_BITS-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [CH_BITS-1:0] CH_COMMA    = 8'h2C;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_END, KIND_NEWLINE, KIND_DCOLON, KIND_COLON, KIND_ARROW, KIND_MINUS,
      KIND_IDENT, KIND_LET, KIND_DATA, KIND_INTERNAL, KIND_MAIN, KIND_INCLUDE,
      KIND_UNIFORM, KIND_IN, KIND_OUT, KIND_TYPE, KIND_NUMBER, KIND_PLUS,
      KIND_MULTIPLY, KIND_DIVIDE, KIND_GREATER, KIND_LESS, KIND_LBRACE,
      KIND_RBRACE, KIND_LPAREN, KIND_RPAREN, KIND_LBRACKET, KIND_RBRACKET,
      KIND_COMMA, KIND_EQUALS, KIND_DOT, KIND_UNKNOWN
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_COLON, MODE_MINUS, MODE_GT, MODE_LT, MODE_IDENT, MODE_NUM
   } mode_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]   length;
      logic [START_BITS-1:0] start;
      kind_type              kind;
      logic                  last;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } token_slot_type;

   typedef struct packed {
      logic                     room;
      logic                     nonempty;
      logic [FIFO_LVL_BITS-1:0] level;
   } fifo_status_type;

   typedef logic [CH_BITS-1:0] kw_buf_type [KEYWORD_CHARS];

   // keyword text left aligned, first character in the top byte
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      KW_BITS'("let")       << (8 * (KEYWORD_CHARS - 3)),
      KW_BITS'("data")      << (8 * (KEYWORD_CHARS - 4)),
      KW_BITS'("@internal") << (8 * (KEYWORD_CHARS - 9)),
      KW_BITS'("@main")     << (8 * (KEYWORD_CHARS - 5)),
      KW_BITS'("@include")  << (8 * (KEYWORD_CHARS - 8)),
      KW_BITS'("@uniform")  << (8 * (KEYWORD_CHARS - 8)),
      KW_BITS'("@in")       << (8 * (KEYWORD_CHARS - 3)),
      KW_BITS'("@out")      << (8 * (KEYWORD_CHARS - 4)),
      KW_BITS'("float")     << (8 * (KEYWORD_CHARS - 5)),
      KW_BITS'("int")       << (8 * (KEYWORD_CHARS - 3))
   };
   localparam int KW_LEN [KW_COUNT] = '{3, 4, 9, 5, 8, 8, 3, 4, 5, 3};
   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_LET, KIND_DATA, KIND_INTERNAL, KIND_MAIN, KIND_INCLUDE,
      KIND_UNIFORM, KIND_IN, KIND_OUT, KIND_TYPE, KIND_TYPE
   };

   function automatic kind_type ident_kind(kw_buf_type kb, logic [LEN_BITS-1:0] len);
      kind_type k;
      logic     hit;
      k = KIND_IDENT;
      for (int w = 0; w < KW_COUNT; w++) begin
         hit = (len == LEN_BITS'(KW_LEN[w]));
         for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (i < KW_LEN[w] &&
                kb[i] != KW_TEXT[w][8*(KEYWORD_CHARS-1-i) +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            k = KW_KIND[w];
         end
      end
      return k;
   endfunction

   function automatic kind_type single_kind(logic [CH_BITS-1:0] c);
      kind_type k;
      unique case (c)
         CH_PLUS:     k = KIND_PLUS;
         CH_STAR:     k = KIND_MULTIPLY;
         CH_SLASH:    k = KIND_DIVIDE;
         CH_LBRACE:   k = KIND_LBRACE;
         CH_RBRACE:   k = KIND_RBRACE;
         CH_LPAREN:   k = KIND_LPAREN;
         CH_RPAREN:   k = KIND_RPAREN;
         CH_LBRACKET: k = KIND_LBRACKET;
         CH_RBRACKET: k = KIND_RBRACKET;
         CH_COMMA:    k = KIND_COMMA;
         CH_EQUALS:   k = KIND_EQUALS;
         CH_DOT:      k = KIND_DOT;
         default:     k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/shader_source_tokenizer.sv
// ----------------------------------------------------------------------------
// shader_source_tokenizer: streaming tokenizer for shader source text
//
//   channel   direction   beat
//   req_      in          one source byte, zero ends the text
//   rsp_      out         one token: kind, start offset, length; tlast on the
//                         final token that a byte causes
//
// one byte is taken per cycle while the token queue has room; a byte that
// closes a pending token and gives a token of its own yields two tokens,
// which the queue takes together. an input register feeds the lexer, which
// writes a four-entry token queue that drives rsp_.
// the input side stalls only while the queue lacks room for two tokens.
// reset clears the lexer and empties the queue; offsets restart at zero.
// ----------------------------------------------------------------------------
module shader_source_tokenizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sst_pkg::CH_BITS-1:0]   req_tdata,   // ch
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sst_pkg::DATA_BITS-1:0] rsp_tdata,   // token_kind, token_start, token_length
   output logic                          rsp_tlast
);
   import sst_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [CH_BITS-1:0] in_ch_ff;

   logic            step;
   logic            pop;
   token_slot_type  flush_tok, emit_tok;
   token_type       head;
   fifo_status_type fifo_stat;

   assign step        = in_valid_ff && fifo_stat.room;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
      end
   end

   sst_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .ch        (in_ch_ff),
      .flush_tok (flush_tok),
      .emit_tok  (emit_tok)
   );

   sst_token_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_a (flush_tok),
      .push_b (emit_tok),
      .pop    (pop),
      .head   (head),
      .status (fifo_stat)
   );

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = fifo_stat.nonempty;
   assign rsp_tdata  = {{DATA_PAD{1'b0}}, head.length, head.start, head.kind};
   assign rsp_tlast  = head.last;

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && head.kind == KIND_END |-> rsp_tlast && head.length == '0)
      else $error("end token without tlast or with nonzero length");

   a_pair_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (head.kind == KIND_DCOLON || head.kind == KIND_ARROW)
      |-> head.length == LEN_BITS'(2))
      else $error("two-character token with wrong length");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.level <= FIFO_LVL_BITS'(FIFO_DEPTH))
      else $error("token queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("beat pending right after reset");

endmodule

### hw/rtl/sst_lexer.sv
// ----------------------------------------------------------------------------
// sst_lexer: tokenizer state machine
// consumes one byte per step and yields up to two tokens: the pending token
// that the byte closes, then the token that the byte itself gives
// ----------------------------------------------------------------------------
module sst_lexer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [sst_pkg::CH_BITS-1:0] ch,
   output sst_pkg::token_slot_type     flush_tok,
   output sst_pkg::token_slot_type     emit_tok
);
   import sst_pkg::*;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic                     dot_ff, dot_in;
   kw_buf_type               kw_ff;

   logic                   kw_we;
   logic [KW_IDX_BITS-1:0] kw_idx;

   logic        is_alpha, is_digit, is_word, starts_word, opens_pair;
   logic        used;
   logic [CH_BITS-1:0] follow;
   kind_type    pair_kind, lone_kind;
   logic        pair_mode;

   assign is_alpha    = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   assign is_digit    = (ch >= "0" && ch <= "9");
   assign is_word     = is_alpha || is_digit || (ch == CH_UNDER);
   assign starts_word = is_alpha || (ch == CH_AT);
   assign opens_pair  = (ch == CH_COLON) || (ch == CH_MINUS) || (ch == CH_GT) ||
                        (ch == CH_LT);

   // second character of the two-character tokens
   always_comb begin
      pair_mode = 1'b1;
      unique case (mode_ff)
         MODE_COLON: begin
            follow = CH_COLON;  pair_kind = KIND_DCOLON;  lone_kind = KIND_COLON;
         end
         MODE_MINUS: begin
            follow = CH_GT;     pair_kind = KIND_ARROW;   lone_kind = KIND_MINUS;
         end
         MODE_GT: begin
            follow = CH_EQUALS; pair_kind = KIND_GREATER; lone_kind = KIND_GREATER;
         end
         MODE_LT: begin
            follow = CH_EQUALS; pair_kind = KIND_LESS;    lone_kind = KIND_LESS;
         end
         default: begin
            follow = CH_NUL;    pair_kind = KIND_UNKNOWN; lone_kind = KIND_UNKNOWN;
            pair_mode = 1'b0;
         end
      endcase
   end

   // byte extends the pending token
   always_comb begin
      case (mode_ff)
         MODE_IDENT: used = is_word;
         MODE_NUM:   used = is_digit || (ch == CH_DOT && !dot_ff);
         default:    used = pair_mode && (ch == follow);
      endcase
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      kw_we    = 1'b0;
      kw_idx   = len_ff[KW_IDX_BITS-1:0];
      pos_in   = pos_ff + POSITION_BITS'(1);

      unique case (mode_ff)
         MODE_IDENT: begin
            if (used) begin
               kw_we = (len_ff < LEN_BITS'(KEYWORD_CHARS));
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + LEN_BITS'(1);
               end
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (used) begin
               if (ch == CH_DOT) begin
                  dot_in = 1'b1;
               end
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + LEN_BITS'(1);
               end
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase

      if (!used) begin
         if (ch == CH_NUL) begin
            mode_in = MODE_IDLE;
            len_in  = '0;
            dot_in  = 1'b0;
            pos_in  = '0;
         end else if (opens_pair || starts_word || is_digit) begin
            start_in = pos_ff;
            len_in   = LEN_BITS'(1);
            if (ch == CH_COLON) begin
               mode_in = MODE_COLON;
            end else if (ch == CH_MINUS) begin
               mode_in = MODE_MINUS;
            end else if (ch == CH_GT) begin
               mode_in = MODE_GT;
            end else if (ch == CH_LT) begin
               mode_in = MODE_LT;
            end else if (starts_word) begin
               mode_in = MODE_IDENT;
               kw_we   = 1'b1;
               kw_idx  = '0;
            end else begin
               mode_in = MODE_NUM;
               dot_in  = 1'b0;
            end
         end
      end
   end

   // token outputs
   always_comb begin
      flush_tok       = '0;
      flush_tok.tok.start = START_BITS'(start_ff);
      unique case (mode_ff)
         MODE_IDENT: begin
            flush_tok.valid      = step && !used;
            flush_tok.tok.kind   = ident_kind(kw_ff, len_ff);
            flush_tok.tok.length = len_ff;
         end
         MODE_NUM: begin
            flush_tok.valid      = step && !used;
            flush_tok.tok.kind   = KIND_NUMBER;
            flush_tok.tok.length = len_ff;
         end
         default: begin
            flush_tok.valid      = step && pair_mode;
            flush_tok.tok.kind   = used ? pair_kind : lone_kind;
            flush_tok.tok.length = used ? LEN_BITS'(2) : LEN_BITS'(1);
         end
      endcase

      emit_tok            = '0;
      emit_tok.tok.start  = START_BITS'(pos_ff);
      emit_tok.tok.last   = 1'b1;
      emit_tok.valid      = step && !used && (ch != CH_SPACE) && !opens_pair &&
                            !starts_word && !is_digit;
      if (ch == CH_NUL) begin
         emit_tok.tok.kind   = KIND_END;
         emit_tok.tok.length = '0;
      end else if (ch == CH_NEWLINE) begin
         emit_tok.tok.kind   = KIND_NEWLINE;
         emit_tok.tok.length = LEN_BITS'(1);
      end else begin
         emit_tok.tok.kind   = single_kind(ch);
         emit_tok.tok.length = LEN_BITS'(1);
      end
      flush_tok.tok.last = !emit_tok.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
      end
   end

   // first characters of the pending identifier
   always_ff @(posedge clock) begin
      if (step && kw_we) begin
         kw_ff[kw_idx] <= ch;
      end
   end

endmodule

### hw/rtl/sst_token_fifo.sv
// ----------------------------------------------------------------------------
// sst_token_fifo: result queue
// takes up to two tokens a cycle, hands out one a cycle
// ----------------------------------------------------------------------------
module sst_token_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  sst_pkg::token_slot_type  push_a,
   input  sst_pkg::token_slot_type  push_b,
   input  logic                     pop,
   output sst_pkg::token_type       head,
   output sst_pkg::fifo_status_type status
);
   import sst_pkg::*;

   token_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ff, rd_in;
   logic [FIFO_LVL_BITS-1:0] level_ff, level_in;

   token_type                first_tok;
   logic                     two;
   logic [FIFO_LVL_BITS-1:0] n_push;

   always_comb begin
      first_tok = push_a.valid ? push_a.tok : push_b.tok;
      two       = push_a.valid && push_b.valid;
      n_push    = FIFO_LVL_BITS'(push_a.valid) + FIFO_LVL_BITS'(push_b.valid);
      wr_in     = wr_ff + n_push[FIFO_PTR_BITS-1:0];
      rd_in     = rd_ff + FIFO_PTR_BITS'(pop);
      level_in  = level_ff + n_push - FIFO_LVL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_a.valid || push_b.valid) begin
         entry_ff[wr_ff] <= first_tok;
      end
      if (two) begin
         entry_ff[wr_ff + FIFO_PTR_BITS'(1)] <= push_b.tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   assign head            = entry_ff[rd_ff];
   assign status.level    = level_ff;
   assign status.nonempty = (level_ff != '0);
   // room for two tokens, whatever leaves this cycle
   assign status.room     = (level_ff <= FIFO_LVL_BITS'(FIFO_DEPTH - 2));

endmodule

### tb/shader_source_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// shader_source_tokenizer_tb: self-checking bench for the source tokenizer
// streams text bytes with random gaps, predicts every token (kind, start,
// length, end-of-byte flag) with a behavioral lexer and checks each rsp_ beat
// in order; covers keywords, operators, numbers, noise bytes and identifiers
// longer than the keyword buffer
// ----------------------------------------------------------------------------
module shader_source_tokenizer_tb;
   import sst_pkg::*;

   typedef struct {
      kind_type              kind;
      logic [START_BITS-1:0] start;
      logic [LEN_BITS-1:0]   length;
      logic                  last;
   } token_rec_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CH_BITS-1:0]   req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   shader_source_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // keywords and near misses
   string word_list [20] = '{
      "let", "data", "@internal", "@main", "@include", "@uniform", "@in", "@out",
      "float", "int", "lets", "@internals", "@inc", "Data", "@", "in", "@int",
      "floats", "_x", "@outs"
   };
   string op_list [20] = '{
      "::", ":", "->", "-", ">=", ">", "<=", "<", "+", "*", "/", "{", "}", "(",
      ")", "[", "]", ",", "=", "."
   };

   logic [CH_BITS-1:0] byte_q [$];
   token_rec_type      token_q [$];
   int                 total_bytes;
   int                 bytes_taken;
   int                 tokens_checked;
   int                 end_markers;
   int                 error_count;
   logic [LEN_BITS-1:0] longest;

   // lexer prediction state
   mode_type              lex_mode = MODE_IDLE;
   logic [POSITION_BITS-1:0] lex_pos = '0;
   logic [START_BITS-1:0] lex_start = '0;
   logic [LEN_BITS-1:0]   lex_len = '0;
   logic                  lex_dot = 1'b0;
   logic [CH_BITS-1:0]    kw_buf [KEYWORD_CHARS] = '{default: '0};

   // handshake bookkeeping
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic word_is(string w);
      if (lex_len != LEN_BITS'(w.len())) return 1'b0;
      for (int i = 0; i < w.len(); i++) begin
         if (kw_buf[i] != w[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic kind_type word_kind();
      if (word_is("let"))       return KIND_LET;
      if (word_is("data"))      return KIND_DATA;
      if (word_is("@internal")) return KIND_INTERNAL;
      if (word_is("@main"))     return KIND_MAIN;
      if (word_is("@include"))  return KIND_INCLUDE;
      if (word_is("@uniform"))  return KIND_UNIFORM;
      if (word_is("@in"))       return KIND_IN;
      if (word_is("@out"))      return KIND_OUT;
      if (word_is("float") || word_is("int")) return KIND_TYPE;
      return KIND_IDENT;
   endfunction

   function automatic kind_type punct_kind(logic [7:0] c);
      case (c)
         CH_PLUS:     return KIND_PLUS;
         CH_STAR:     return KIND_MULTIPLY;
         CH_SLASH:    return KIND_DIVIDE;
         CH_LBRACE:   return KIND_LBRACE;
         CH_RBRACE:   return KIND_RBRACE;
         CH_LPAREN:   return KIND_LPAREN;
         CH_RPAREN:   return KIND_RPAREN;
         CH_LBRACKET: return KIND_LBRACKET;
         CH_RBRACKET: return KIND_RBRACKET;
         CH_COMMA:    return KIND_COMMA;
         CH_EQUALS:   return KIND_EQUALS;
         CH_DOT:      return KIND_DOT;
         default:     return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic token_rec_type make_token(kind_type k, logic [START_BITS-1:0] s,
                                                logic [LEN_BITS-1:0] l);
      token_rec_type t;
      t.kind = k;
      t.start = s;
      t.length = l;
      t.last = 1'b0;
      return t;
   endfunction

   // advance the lexer by one byte and queue the tokens it closes or gives
   task automatic tokenize_byte(input logic [7:0] c);
      token_rec_type         step_out [$];
      token_rec_type         t;
      logic                  used;
      logic [POSITION_BITS-1:0] here;
      logic [POSITION_BITS-1:0] next_pos;
      used = 1'b0;
      here = lex_pos;
      next_pos = here + POSITION_BITS'(1);
      case (lex_mode)
         MODE_COLON: begin
            if (c == CH_COLON) begin
               step_out.push_back(make_token(KIND_DCOLON, lex_start, LEN_BITS'(2)));
               used = 1'b1;
            end else begin
               step_out.push_back(make_token(KIND_COLON, lex_start, LEN_BITS'(1)));
            end
            lex_mode = MODE_IDLE;
         end
         MODE_MINUS: begin
            if (c == CH_GT) begin
               step_out.push_back(make_token(KIND_ARROW, lex_start, LEN_BITS'(2)));
               used = 1'b1;
            end else begin
               step_out.push_back(make_token(KIND_MINUS, lex_start, LEN_BITS'(1)));
            end
            lex_mode = MODE_IDLE;
         end
         MODE_GT, MODE_LT: begin
            // the comparison and its '=' form share one kind
            if (c == CH_EQUALS) begin
               step_out.push_back(make_token(lex_mode == MODE_GT ? KIND_GREATER : KIND_LESS,
                                             lex_start, LEN_BITS'(2)));
               used = 1'b1;
            end else begin
               step_out.push_back(make_token(lex_mode == MODE_GT ? KIND_GREATER : KIND_LESS,
                                             lex_start, LEN_BITS'(1)));
            end
            lex_mode = MODE_IDLE;
         end
         MODE_IDENT: begin
            if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
               if (lex_len < LEN_BITS'(KEYWORD_CHARS)) kw_buf[lex_len[KW_IDX_BITS-1:0]] = c;
               if (lex_len != LEN_MAX) lex_len = lex_len + LEN_BITS'(1);
               used = 1'b1;
            end else begin
               step_out.push_back(make_token(word_kind(), lex_start, lex_len));
               lex_mode = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (is_digit(c) || (c == CH_DOT && !lex_dot)) begin
               if (c == CH_DOT) lex_dot = 1'b1;
               if (lex_len != LEN_MAX) lex_len = lex_len + LEN_BITS'(1);
               used = 1'b1;
            end else begin
               step_out.push_back(make_token(KIND_NUMBER, lex_start, lex_len));
               lex_mode = MODE_IDLE;
            end
         end
         default: lex_mode = MODE_IDLE;
      endcase

      // a byte not absorbed by the pending token starts over from idle
      if (!used) begin
         if (c == CH_NUL) begin
            step_out.push_back(make_token(KIND_END, START_BITS'(here), '0));
            lex_mode = MODE_IDLE;
            lex_len = '0;
            lex_dot = 1'b0;
            next_pos = '0;
         end else if (c == CH_SPACE) begin
         end else if (c == CH_NEWLINE) begin
            step_out.push_back(make_token(KIND_NEWLINE, START_BITS'(here), LEN_BITS'(1)));
         end else if (c == CH_COLON || c == CH_MINUS || c == CH_GT || c == CH_LT ||
                      is_letter(c) || c == CH_AT || is_digit(c)) begin
            lex_start = START_BITS'(here);
            lex_len = LEN_BITS'(1);
            if (c == CH_COLON)      lex_mode = MODE_COLON;
            else if (c == CH_MINUS) lex_mode = MODE_MINUS;
            else if (c == CH_GT)    lex_mode = MODE_GT;
            else if (c == CH_LT)    lex_mode = MODE_LT;
            else if (is_digit(c)) begin
               lex_mode = MODE_NUM;
               lex_dot = 1'b0;
            end else begin
               lex_mode = MODE_IDENT;
               kw_buf[0] = c;
            end
         end else begin
            step_out.push_back(make_token(punct_kind(c), START_BITS'(here), LEN_BITS'(1)));
         end
      end
      lex_pos = next_pos;

      if (step_out.size() > 0) begin
         t = step_out.pop_back();
         t.last = 1'b1;
         step_out.push_back(t);
      end
      foreach (step_out[i]) token_q.push_back(step_out[i]);
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("mismatch @%0t: %s", $time, msg);
   endtask

   task automatic check_token();
      token_rec_type         want;
      logic [KIND_BITS-1:0]  got_kind;
      logic [START_BITS-1:0] got_start;
      logic [LEN_BITS-1:0]   got_len;
      logic [DATA_PAD-1:0]   got_pad;
      got_kind  = rsp_tdata[KIND_BITS-1:0];
      got_start = rsp_tdata[KIND_BITS +: START_BITS];
      got_len   = rsp_tdata[KIND_BITS+START_BITS +: LEN_BITS];
      got_pad   = rsp_tdata[DATA_BITS-1:TOKEN_BITS];
      if (token_q.size() == 0) begin
         report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                   got_kind, got_start, got_len));
         return;
      end
      want = token_q.pop_front();
      tokens_checked++;
      if (want.kind == KIND_END) end_markers++;
      if (want.length > longest) longest = want.length;
      if (got_kind != want.kind)
         report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                   tokens_checked, got_kind, want.kind));
      if (got_start != want.start)
         report_mismatch($sformatf("token %0d start %0d, expected %0d",
                                   tokens_checked, got_start, want.start));
      if (got_len != want.length)
         report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                   tokens_checked, got_len, want.length));
      if (rsp_tlast !== want.last)
         report_mismatch($sformatf("token %0d tlast %b, expected %b",
                                   tokens_checked, rsp_tlast, want.last));
      if (got_pad != '0)
         report_mismatch($sformatf("token %0d padding bits %b", tokens_checked, got_pad));
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_token();
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (req_taken) begin
            if ($urandom_range(0, 99) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 7);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (byte_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_q.pop_front();
         end
      end
   end

   // token sink with random back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 7);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + (r - 26));
      if (r < 62) return 8'("0" + (r - 52));
      return CH_UNDER;
   endfunction

   task automatic add_piece();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         add_text(word_list[$urandom_range(0, 19)]);
      end else if (r < 45) begin
         if ($urandom_range(0, 4) == 0) byte_q.push_back(CH_AT);
         else if ($urandom_range(0, 1)) byte_q.push_back(8'("a" + $urandom_range(0, 25)));
         else byte_q.push_back(8'("A" + $urandom_range(0, 25)));
         n = $urandom_range(0, 12);
         repeat (n) byte_q.push_back(word_char());
      end else if (r < 60) begin
         byte_q.push_back(8'("0" + $urandom_range(0, 9)));
         n = $urandom_range(0, 6);
         repeat (n) byte_q.push_back($urandom_range(0, 4) == 0 ? CH_DOT
                                                              : 8'("0" + $urandom_range(0, 9)));
      end else if (r < 80) begin
         add_text(op_list[$urandom_range(0, 19)]);
      end else if (r < 87) begin
         byte_q.push_back(CH_NEWLINE);
      end else if (r < 96) begin
         byte_q.push_back(8'($urandom_range(1, 255)));
      end else begin
         byte_q.push_back(CH_NUL);
      end
      r = $urandom_range(0, 9);
      if (r < 5) byte_q.push_back(CH_SPACE);
      else if (r == 5) add_text("   ");
   endtask

   initial begin
      int directed_end;
      error_count = 0;
      bytes_taken = 0;
      tokens_checked = 0;
      end_markers = 0;
      longest = '0;

      // pairs, lone forms, second dot in a number, unlisted bytes
      add_text("let 1.2.3:::a-->>=>x<=<");
      byte_q.push_back(8'h09);
      byte_q.push_back(8'hFF);
      byte_q.push_back(CH_NEWLINE);
      byte_q.push_back(CH_NUL);
      directed_end = byte_q.size();

      while (byte_q.size() < directed_end + 800) add_piece();

      add_text(" @main 7\n");
      byte_q.push_back(CH_NUL);
      total_bytes = byte_q.size();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (bytes_taken < total_bytes || token_q.size() != 0);
      repeat (12) @(negedge clock);

      $display("sent %0d source bytes, checked %0d tokens (%0d end markers)",
               bytes_taken, tokens_checked, end_markers);
      $display("longest token %0d bytes, mismatches %0d", longest, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("timeout with %0d tokens outstanding", token_q.size());
      $display("status: fail");
      $finish;
   end

endmodule
